/* hdl/wsp_pkg.sv */
// ============================================================================
// Windowed standard deviation and peak-to-peak: shared package
// Widths, register map, the job record handed from front end to back end.
// ============================================================================
`default_nettype none

package wsp_pkg;

    localparam int X_W       = 16;
    localparam int Y_W       = 16;
    localparam int CNT_W     = 10;
    localparam int SUM_W     = 26;
    localparam int SQ_W      = 41;
    localparam int PTP_W     = 16;
    localparam int STD_W     = 20;
    localparam int MAG_W     = 25;
    localparam int A_W       = CNT_W + SQ_W;
    localparam int B_W       = 2 * MAG_W;
    localparam int NUM_W     = 50;
    localparam int RAD_W     = NUM_W + 8;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int STEP_W    = $clog2(ROOT_W);
    localparam int REM_W     = ROOT_W + 3;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int MAX_WINDOW  = 1023;
    localparam int COUNT_MAX   = (1 << CNT_W) - 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] WINDOW_RESET = 10'd100;

    // Register index, decoded from paddr[2].
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum_y;
        logic [SQ_W-1:0]         sum_sq_y;
        logic [PTP_W-1:0]        peak_to_peak;
    } wsp_job_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MULT = 6'b000010,
        ST_DIFF = 6'b000100,
        ST_SQRT = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } wsp_state_t;

endpackage

`default_nettype wire

/* hdl/wsp_front.sv */
// ============================================================================
// Windowed statistics: front end
// Accepts sample beats, accumulates sum, sum of squares and extremes, and
// pushes one job per finished window into the queue.
// ============================================================================
`default_nettype none

module wsp_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [wsp_pkg::CNT_W-1:0]      window_length,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [wsp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           q_full,
    output logic                                q_push,
    output wsp_pkg::wsp_job_t                   q_data
);
    import wsp_pkg::*;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [X_W-1:0]   min_reg, min_next;
    logic signed [X_W-1:0]   max_reg, max_next;
    logic                    have_reg;

    logic signed [X_W-1:0]   x_w;
    logic signed [Y_W-1:0]   y_w;
    logic signed [2*Y_W-1:0] prod_w;
    logic [15:0]             win_w;
    logic                    accept_w;
    logic                    done_w;
    logic [X_W:0]            ptp_w;

    assign s_tready = !q_full;
    assign accept_w = s_tvalid && s_tready;

    assign x_w    = $signed(s_tdata[X_W-1:0]);
    assign y_w    = $signed(s_tdata[X_W+Y_W-1:X_W]);
    assign prod_w = y_w * y_w;

    always_comb begin
        win_w = {6'b0, window_length};
        if (window_length == '0) begin
            win_w = 16'd1;
        end else if (win_w > 16'(MAX_WINDOW)) begin
            win_w = 16'(MAX_WINDOW);
        end
    end

    always_comb begin
        cnt_next = (cnt_reg < CNT_W'(COUNT_MAX)) ? cnt_reg + 1'b1 : cnt_reg;
        sum_next = sum_reg + {{(SUM_W-Y_W){y_w[Y_W-1]}}, y_w};
        sq_next  = sq_reg + {{(SQ_W-2*Y_W){1'b0}}, prod_w};
        if (!have_reg) begin
            min_next = x_w;
            max_next = x_w;
        end else begin
            min_next = (x_w < min_reg) ? x_w : min_reg;
            max_next = (x_w > max_reg) ? x_w : max_reg;
        end
    end

    assign done_w = {6'b0, cnt_next} >= win_w;
    assign ptp_w  = {max_next[X_W-1], max_next} - {min_next[X_W-1], min_next};

    assign q_push              = accept_w && done_w;
    assign q_data.count        = cnt_next;
    assign q_data.sum_y        = sum_next;
    assign q_data.sum_sq_y     = sq_next;
    assign q_data.peak_to_peak = ptp_w[PTP_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            cnt_reg  <= '0;
            min_reg  <= '0;
            max_reg  <= '0;
            have_reg <= 1'b0;
        end else if (accept_w) begin
            if (done_w) begin
                sum_reg  <= '0;
                sq_reg   <= '0;
                cnt_reg  <= '0;
                min_reg  <= '0;
                max_reg  <= '0;
                have_reg <= 1'b0;
            end else begin
                sum_reg  <= sum_next;
                sq_reg   <= sq_next;
                cnt_reg  <= cnt_next;
                min_reg  <= min_next;
                max_reg  <= max_next;
                have_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/wsp_queue.sv */
// ============================================================================
// Windowed statistics: job queue
// Short first-in first-out queue of finished windows between the two ends.
// ============================================================================
`default_nettype none

module wsp_queue #(
    parameter int DEPTH = wsp_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire wsp_pkg::wsp_job_t push_data,
    input  wire logic              pop,
    output wsp_pkg::wsp_job_t      pop_data,
    output logic                   full,
    output logic                   empty
);
    import wsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_Q = $clog2(DEPTH + 1);

    wsp_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_Q-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full     = fill_reg == CNT_Q'(DEPTH);
    assign empty    = fill_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_comb begin
        wr_next   = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        rd_next   = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_next;
            end
            if (do_pop) begin
                rd_reg <= rd_next;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/wsp_back.sv */
// ============================================================================
// Windowed statistics: back end
// Takes one window job at a time: variance numerator, bit-serial square root,
// bit-serial division by the count, then the result into the output register.
// ============================================================================
`default_nettype none

module wsp_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_empty,
    input  wire wsp_pkg::wsp_job_t              q_data,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [wsp_pkg::M_TDATA_W-1:0]       m_tdata
);
    import wsp_pkg::*;

    wsp_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     n_reg;
    logic [PTP_W-1:0]     ptp_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [A_W-1:0]       a_reg;
    logic [B_W-1:0]       b_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [CNT_W-1:0]     drem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [SUM_W-1:0]     abs_w;
    logic [A_W-1:0]       diff_w;
    logic [REM_W+1:0]     srem_w;
    logic [REM_W+1:0]     trial_w;
    logic                 sfit_w;
    logic [CNT_W:0]       dtry_w;
    logic                 dfit_w;
    logic                 last_w;
    logic                 load_out_w;

    assign abs_w   = q_data.sum_y[SUM_W-1] ? SUM_W'(-q_data.sum_y) : q_data.sum_y;
    assign diff_w  = a_reg - A_W'(b_reg);
    assign srem_w  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial_w = (REM_W+2)'({root_reg, 2'b01});
    assign sfit_w  = srem_w >= trial_w;
    assign dtry_w  = {drem_reg, root_reg[ROOT_W-1]};
    assign dfit_w  = dtry_w >= {1'b0, n_reg};
    assign last_w  = step_reg == STEP_W'(ROOT_W - 1);

    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign load_out_w = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQRT;
            ST_SQRT: begin
                if (last_w) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (last_w) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out_w) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out_w) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                n_reg   <= q_data.count;
                ptp_reg <= q_data.peak_to_peak;
                sq_reg  <= q_data.sum_sq_y;
                mag_reg <= abs_w[MAG_W-1:0];
            end
            ST_MULT: begin
                a_reg <= A_W'(n_reg) * A_W'(sq_reg);
                b_reg <= B_W'(mag_reg) * B_W'(mag_reg);
            end
            ST_DIFF: begin
                rad_reg  <= (a_reg > A_W'(b_reg)) ? {diff_w[NUM_W-1:0], 8'b0} : '0;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
            end
            ST_SQRT: begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= sfit_w ? REM_W'(srem_w - trial_w) : REM_W'(srem_w);
                root_reg <= {root_reg[ROOT_W-2:0], sfit_w};
                drem_reg <= '0;
                step_reg <= last_w ? '0 : step_reg + 1'b1;
            end
            ST_DIV: begin
                drem_reg <= dfit_w ? CNT_W'(dtry_w - {1'b0, n_reg}) : CNT_W'(dtry_w);
                root_reg <= {root_reg[ROOT_W-2:0], dfit_w};
                step_reg <= last_w ? '0 : step_reg + 1'b1;
            end
            ST_DONE: begin
                if (load_out_w) begin
                    out_data_reg <= {{(M_TDATA_W-STD_W-PTP_W){1'b0}},
                                     ptp_reg, root_reg[STD_W-1:0]};
                end
            end
            default: begin
                step_reg <= '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/window_std_and_peak_to_peak_top.sv */
// ============================================================================
// Windowed standard deviation and peak-to-peak: top level
// Sample stream in, one statistics beat per window out, APB register port.
// ============================================================================
// The input stream takes one sample beat per clock cycle as long as the job
// queue has room; the queue only fills when windows finish faster than the
// back end can process them. Each finished window takes the back end through
// one pop, one multiply, one subtract, 29 square-root steps and 29 division
// steps and one output load, set by the one-bit-per-cycle root and divide unit.
// Windows at least as long as that work therefore stream at full rate while
// the output is not stalled; shorter windows are paced by the back end.
`default_nettype none

module window_std_and_peak_to_peak_top #(
    parameter int QUEUE_DEPTH = wsp_pkg::QUEUE_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: accel_x [15:0], accel_y [31:16]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [wsp_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: std_dev_y_q4 [19:0], peak_to_peak_x [35:20], zero [39:36]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [wsp_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [wsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wsp_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import wsp_pkg::*;

    logic [CNT_W-1:0] window_reg;
    logic             wr_en_w;
    logic             q_push, q_pop, q_full, q_empty;
    wsp_job_t         push_data, pop_data;

    assign pready  = 1'b1;
    assign wr_en_w = psel && penable && pwrite && pready
                     && (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata  = (paddr[2] == REG_WINDOW_LENGTH)
                     ? {{(APB_DATA_W-CNT_W){1'b0}}, window_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (wr_en_w) begin
            window_reg <= pwdata[CNT_W-1:0];
        end
    end

    wsp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .window_length (window_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (push_data)
    );

    wsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    wsp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* hdl/wsp_checker.sv */
// ============================================================================
// Windowed statistics: port checker
// Watches the top level's ports and is bound to every instance of it.
// ============================================================================
`default_nettype none

module wsp_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [wsp_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic                            psel,
    input wire logic                            penable,
    input wire logic                            pwrite,
    input wire logic [wsp_pkg::APB_ADDR_W-1:0]  paddr,
    input wire logic [wsp_pkg::APB_DATA_W-1:0]  pwdata,
    input wire logic [wsp_pkg::APB_DATA_W-1:0]  prdata
);
    import wsp_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_std_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[STD_W-1:0] <= 20'd524280)
        else $error("standard deviation above its largest reachable value");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:STD_W+16] == '0)
        else $error("padding bits of the result beat are not zero");

    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH)
        |=> (paddr[2] != REG_WINDOW_LENGTH)
            || (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0])))
        else $error("window length does not read back as written");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind window_std_and_peak_to_peak_top wsp_checker u_wsp_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// Windowed standard deviation and peak-to-peak: testbench
// Streams accelerometer sample pairs into the block, predicts each window's
// standard deviation of y and peak-to-peak of x, and checks every result beat.
// The window length is changed between phases over the APB port and read back.
// ============================================================================

module tb_top;

    import wsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 80;
    localparam int RANDOM_ITEMS   = 80;

    localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_LENGTH, 2'b00};

    typedef enum {PAT_FULL, PAT_RAIL, PAT_NARROW} pattern_t;

    typedef struct {
        logic [STD_W-1:0] std_q4;
        logic [PTP_W-1:0] ptp;
    } stats_t;

    logic                    aclk;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    logic [S_TDATA_W-1:0] pending_samples[$];
    stats_t               expected_stats[$];
    int                   beats_pending  = 0;
    int                   mismatch_count = 0;
    int                   results_seen   = 0;
    int                   quiet_cycles   = 0;
    int                   send_gap       = 0;
    int                   sink_gap       = 0;
    int                   hold_left      = 0;
    bit                   gaps_send      = 1'b1;
    bit                   gaps_recv      = 1'b1;
    bit                   hold_req       = 1'b0;
    bit                   hold_seen      = 1'b0;

    logic [CNT_W-1:0] window_cfg   = WINDOW_RESET;
    int               acc_count    = 0;
    longint           acc_sum_y    = 0;
    longint unsigned  acc_sumsq_y  = 0;
    int               acc_min_x    = 0;
    int               acc_max_x    = 0;
    bit               acc_have_x   = 1'b0;

    window_std_and_peak_to_peak_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 120);
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic void accumulate_sample(input logic signed [X_W-1:0] x,
                                              input logic signed [Y_W-1:0] y);
        int              xi;
        longint          yi;
        int              win;
        longint unsigned n;
        longint unsigned mag;
        longint unsigned lhs;
        longint unsigned rhs;
        longint unsigned num;
        longint unsigned sd;
        stats_t          e;
        xi  = int'(x);
        yi  = longint'(y);
        win = (window_cfg == 0) ? 1 : int'(window_cfg);
        if (acc_count < COUNT_MAX) begin
            acc_count++;
        end
        acc_sum_y   += yi;
        acc_sumsq_y += longint'(yi * yi);
        if (!acc_have_x) begin
            acc_min_x  = xi;
            acc_max_x  = xi;
            acc_have_x = 1'b1;
        end else begin
            if (xi < acc_min_x) acc_min_x = xi;
            if (xi > acc_max_x) acc_max_x = xi;
        end
        if (acc_count < win) begin
            return;
        end
        n   = longint'(acc_count);
        mag = (acc_sum_y < 0) ? -acc_sum_y : acc_sum_y;
        lhs = n * acc_sumsq_y;
        rhs = mag * mag;
        num = (lhs > rhs) ? lhs - rhs : 0;
        sd  = root_floor(num << 8) / n;
        e.std_q4 = sd[STD_W-1:0];
        e.ptp    = PTP_W'(acc_max_x - acc_min_x);
        expected_stats.push_back(e);
        acc_count   = 0;
        acc_sum_y   = 0;
        acc_sumsq_y = 0;
        acc_min_x   = 0;
        acc_max_x   = 0;
        acc_have_x  = 1'b0;
    endfunction

    // Sample driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                accumulate_sample(s_tdata[X_W-1:0], s_tdata[X_W+:Y_W]);
                beats_pending--;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples.pop_front();
                    send_gap <= gaps_send ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result sink readiness, including the long hold-off on request.
    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_gap  <= 0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (sink_gap != 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            gap = gaps_recv ? pick_gap() : 0;
            m_tready <= (gap == 0);
            sink_gap <= (gap == 0) ? 0 : gap - 1;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_stats.size() == 0) begin
                note_mismatch($sformatf("result beat %0d with nothing expected: %h",
                                        results_seen, m_tdata));
            end else begin
                want = expected_stats.pop_front();
                if (m_tdata[STD_W-1:0] !== want.std_q4 ||
                    m_tdata[STD_W+:PTP_W] !== want.ptp ||
                    m_tdata[M_TDATA_W-1:STD_W+PTP_W] !== '0) begin
                    note_mismatch($sformatf(
                        "beat %0d: expected std %0d p2p %0d, got std %0d p2p %0d pad %h",
                        results_seen, want.std_q4, want.ptp, m_tdata[STD_W-1:0],
                        m_tdata[STD_W+:PTP_W], m_tdata[M_TDATA_W-1:STD_W+PTP_W]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_transfer(input bit is_write, input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= WINDOW_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input int unsigned win);
        logic [APB_DATA_W-1:0] word;
        logic [APB_DATA_W-1:0] rd;
        word = $urandom();
        word[CNT_W-1:0] = win[CNT_W-1:0];
        apb_transfer(1'b1, word, rd);
        window_cfg <= win[CNT_W-1:0];
        apb_transfer(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(win[CNT_W-1:0])) begin
            note_mismatch($sformatf("window_length read back %h, expected %0d",
                                    rd, win[CNT_W-1:0]));
        end
    endtask

    task automatic queue_pair(input logic signed [X_W-1:0] x, input logic signed [Y_W-1:0] y);
        pending_samples.push_back({y, x});
        beats_pending++;
    endtask

    task automatic drain();
        while (beats_pending != 0 || expected_stats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_pattern(input pattern_t pat, input int count);
        logic [15:0] x;
        logic [15:0] y;
        for (int i = 0; i < count; i++) begin
            case (pat)
                PAT_RAIL: begin
                    y = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                    case ($urandom_range(0, 2))
                        0:       x = 16'h8000;
                        1:       x = 16'h7FFF;
                        default: x = 16'($urandom());
                    endcase
                end
                PAT_NARROW: begin
                    x = 16'($urandom_range(0, 63) - 32);
                    y = 16'($urandom_range(0, 15) + 1000);
                end
                default: begin
                    x = 16'($urandom());
                    y = 16'($urandom());
                end
            endcase
            queue_pair(x, y);
        end
    endtask

    initial begin
        logic [APB_DATA_W-1:0] rd;
        int                    random_total;
        int                    win;
        int                    eff;
        int                    reps;
        int                    extra;
        int                    r;
        pattern_t              pat;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        apb_transfer(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(WINDOW_RESET)) begin
            note_mismatch($sformatf("window_length after reset %h", rd));
        end

        // Single-sample windows, at the rails of both fields and near zero.
        set_window(1);
        @(negedge aclk);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh0000, 16'sh0000);
        queue_pair(16'shFFFF, 16'sh0001);
        drain();

        // A zero window length behaves as one sample per window.
        set_window(0);
        @(negedge aclk);
        queue_pair(16'sh0005, 16'shFFF9);
        drain();

        set_window(2);
        @(negedge aclk);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh7FFF, 16'sh7FFF);
        queue_pair(16'sh7FFF, 16'sh8000);
        queue_pair(16'sh7FFF, 16'sh8000);
        drain();

        set_window(4);
        @(negedge aclk);
        queue_pair(16'sh0000, 16'sh7FFF);
        queue_pair(16'sh0000, 16'sh8000);
        queue_pair(16'sh0000, 16'sh7FFF);
        queue_pair(16'sh0000, 16'sh8000);
        drain();

        // Shortening the window part way through closes it on the next sample.
        set_window(5);
        @(negedge aclk);
        queue_pair(16'sh1234, 16'sh0100);
        queue_pair(16'shF00D, 16'shFE00);
        queue_pair(16'sh0042, 16'sh0033);
        drain();
        set_window(2);
        @(negedge aclk);
        queue_pair(16'sh7000, 16'sh9000);
        drain();

        // Longest window, with y on its rails.
        gaps_send <= 1'b1;
        gaps_recv <= 1'b1;
        set_window(MAX_WINDOW);
        @(negedge aclk);
        queue_pattern(PAT_RAIL, MAX_WINDOW);
        drain();

        // Receiver holds off while the sender keeps offering one-sample windows.
        gaps_send <= 1'b0;
        set_window(1);
        @(posedge aclk);
        hold_req <= ~hold_req;
        @(negedge aclk);
        queue_pattern(PAT_FULL, 40);
        drain();

        random_total = 0;
        while (random_total < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                win = 0;
            end else if (r < 35) begin
                win = $urandom_range(1, 8);
            end else if (r < 75) begin
                win = $urandom_range(9, 64);
            end else if (r < 95) begin
                win = $urandom_range(65, 200);
            end else begin
                win = $urandom_range(201, 400);
            end
            eff   = (win == 0) ? 1 : win;
            reps  = (eff <= 8) ? $urandom_range(2, 8) : (eff <= 64) ? $urandom_range(1, 2) : 1;
            extra = $urandom_range(0, (eff > 20) ? 20 : eff - 1);
            r = $urandom_range(0, 3);
            pat = (r < 2) ? PAT_FULL : (r == 2) ? PAT_RAIL : PAT_NARROW;
            gaps_send <= ($urandom_range(0, 3) != 0);
            gaps_recv <= ($urandom_range(0, 3) != 0);
            set_window(win);
            @(negedge aclk);
            queue_pattern(pat, eff * reps + extra);
            random_total += eff * reps + extra;
            drain();
        end

        // Close out any partial window before the end.
        set_window(1);
        @(negedge aclk);
        queue_pattern(PAT_FULL, 1);
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_stats.size() == 0 && beats_pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
